[rtl/ewh_pkg.sv]
// Shared types and constants for the equal-width histogram.
// Holds command codes, register indexes and the beat structs between the top and the store.
// No dependencies.
`default_nettype none

package ewh_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int SELECT_W    = 7;
    localparam int INDEX_W     = 7;
    localparam int OUT_COUNT_W = 32;
    localparam int WIDTH_W     = 31;
    localparam int BINS_W      = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;

    typedef logic [1:0] ewh_cmd_t;

    localparam ewh_cmd_t CMD_ADD   = 2'd0;
    localparam ewh_cmd_t CMD_READ  = 2'd1;
    localparam ewh_cmd_t CMD_CLEAR = 2'd2;
    localparam ewh_cmd_t CMD_RSVD  = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_LOW_EDGE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIN_WIDTH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BINS_IN_USE = 2'd2;

    // One operation handed to the count store.
    typedef struct packed {
        ewh_cmd_t              cmd;        // CMD_ADD, CMD_READ or CMD_CLEAR
        logic                  in_range;   // address lies inside the store
        logic                  clamped;
        logic [INDEX_W-1:0]    bin_index;  // index reported in the result
    } ewh_op_t;

    // One result coming back from the count store.
    typedef struct packed {
        logic [INDEX_W-1:0]     bin_index;
        logic [OUT_COUNT_W-1:0] bin_count;
        logic                   clamped;
    } ewh_result_t;

endpackage

`default_nettype wire

[rtl/ewh_binner.sv]
// Bin finder: maps a signed Q16.16 sample to a bin index with saturation at both ends.
// Range check by one multiply, then a restoring divide at one quotient bit per cycle.
// Depends on ewh_pkg.
`default_nettype none

module ewh_binner #(
    parameter int NUM_BINS = 128
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [ewh_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [ewh_pkg::SAMPLE_W-1:0]  low_edge,
    input  wire logic [ewh_pkg::WIDTH_W-1:0]   bin_width,
    input  wire logic [ewh_pkg::BINS_W-1:0]    bins_in_use,
    output logic                               done,
    output logic [$clog2(NUM_BINS)-1:0]        bin,
    output logic                               clamped
);
    import ewh_pkg::*;

    localparam int IDX_BITS  = $clog2(NUM_BINS);
    localparam int NB_BITS   = $clog2(NUM_BINS + 1);
    localparam int CW        = IDX_BITS + SAMPLE_W + 1;
    localparam int PROD_W    = NB_BITS + WIDTH_W;
    localparam int STEP_BITS = $clog2(IDX_BITS + 1);

    localparam logic [1:0] BS_IDLE  = 2'd0;
    localparam logic [1:0] BS_LIMIT = 2'd1;
    localparam logic [1:0] BS_CHECK = 2'd2;
    localparam logic [1:0] BS_DIV   = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [SAMPLE_W:0]       diff_reg, diff_next;
    logic [WIDTH_W-1:0]      w_reg, w_next;
    logic [NB_BITS-1:0]      n_reg, n_next;
    logic [CW-1:0]           limit_reg, limit_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic [CW-1:0]           dvs_reg, dvs_next;
    logic [IDX_BITS-1:0]     q_reg, q_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;
    logic                    done_reg, done_next;
    logic [IDX_BITS-1:0]     bin_reg, bin_next;
    logic                    clamp_reg, clamp_next;
    logic [PROD_W-1:0]       prod;
    logic [CW-1:0]           diff_ext;
    logic                    ge;

    assign prod     = n_reg * w_reg;
    assign diff_ext = CW'(diff_reg[SAMPLE_W-1:0]);
    assign ge       = (rem_reg >= dvs_reg);

    always_comb begin
        state_next = state_reg;
        diff_next  = diff_reg;
        w_next     = w_reg;
        n_next     = n_reg;
        limit_next = limit_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        q_next     = q_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        bin_next   = bin_reg;
        clamp_next = clamp_reg;
        unique case (state_reg)
            BS_IDLE: begin
                if (start) begin
                    diff_next = {sample[SAMPLE_W-1], sample}
                              - {low_edge[SAMPLE_W-1], low_edge};
                    w_next    = (bin_width == '0) ? WIDTH_W'(1) : bin_width;
                    if (bins_in_use == '0) begin
                        n_next = NB_BITS'(1);
                    end else if (32'(bins_in_use) > NUM_BINS) begin
                        n_next = NB_BITS'(NUM_BINS);
                    end else begin
                        n_next = NB_BITS'(bins_in_use);
                    end
                    state_next = BS_LIMIT;
                end
            end
            BS_LIMIT: begin
                // end of the last bin in use, relative to low_edge
                limit_next = CW'(prod);
                state_next = BS_CHECK;
            end
            BS_CHECK: begin
                if (diff_reg[SAMPLE_W]) begin
                    bin_next   = '0;
                    clamp_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = BS_IDLE;
                end else if (diff_ext >= limit_reg) begin
                    bin_next   = IDX_BITS'(n_reg - NB_BITS'(1));
                    clamp_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = BS_IDLE;
                end else begin
                    // quotient is below the bin count, so IDX_BITS steps suffice
                    rem_next   = diff_ext;
                    dvs_next   = CW'(w_reg) << (IDX_BITS - 1);
                    q_next     = '0;
                    step_next  = STEP_BITS'(IDX_BITS);
                    state_next = BS_DIV;
                end
            end
            BS_DIV: begin
                if (ge) begin
                    rem_next = rem_reg - dvs_reg;
                end
                dvs_next  = dvs_reg >> 1;
                q_next    = IDX_BITS'({q_reg, ge});
                step_next = step_reg - STEP_BITS'(1);
                if (step_reg == STEP_BITS'(1)) begin
                    bin_next   = IDX_BITS'({q_reg, ge});
                    clamp_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = BS_IDLE;
                end
            end
            default: begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        diff_reg  <= diff_next;
        w_reg     <= w_next;
        n_reg     <= n_next;
        limit_reg <= limit_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        q_reg     <= q_next;
        step_reg  <= step_next;
        bin_reg   <= bin_next;
        clamp_reg <= clamp_next;
    end

    assign done    = done_reg;
    assign bin     = bin_reg;
    assign clamped = clamp_reg;

endmodule

`default_nettype wire

[rtl/ewh_bin_store.sv]
// Count store: one synchronous memory of bin counts with a read-modify-write pipe.
// Sweeps zeros through every entry after reset. The user keeps one operation in
// flight at a time; the store does not enforce it. Depends on ewh_pkg.
`default_nettype none

module ewh_bin_store #(
    parameter int NUM_BINS   = 128,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        op_valid,
    input  wire ewh_pkg::ewh_op_t            op,
    input  wire logic [$clog2(NUM_BINS)-1:0] op_addr,
    output logic                             busy,
    output logic                             res_valid,
    output ewh_pkg::ewh_result_t             res
);
    import ewh_pkg::*;

    localparam int IDX_BITS = $clog2(NUM_BINS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] mem [NUM_BINS];

    logic                  sweep_reg;
    logic [IDX_BITS-1:0]   sweep_addr_reg;
    logic                  p_valid_reg;
    ewh_op_t               p_op_reg;
    logic [IDX_BITS-1:0]   p_addr_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0] inc_count;

    assign inc_count = (rd_data_reg == COUNT_MAX) ? rd_data_reg
                                                  : rd_data_reg + COUNT_BITS'(1);

    always_comb begin
        wr_en         = 1'b0;
        wr_addr       = p_addr_reg;
        wr_data       = '0;
        res.bin_index = p_op_reg.bin_index;
        res.clamped   = 1'b0;
        res.bin_count = '0;
        if (sweep_reg) begin
            wr_en   = 1'b1;
            wr_addr = sweep_addr_reg;
        end else if (p_valid_reg) begin
            case (p_op_reg.cmd)
                CMD_ADD: begin
                    wr_en         = 1'b1;
                    wr_data       = inc_count;
                    res.clamped   = p_op_reg.clamped;
                    res.bin_count = OUT_COUNT_W'(inc_count);
                end
                CMD_CLEAR: begin
                    wr_en = p_op_reg.in_range;
                end
                default: begin
                    res.bin_count = p_op_reg.in_range ? OUT_COUNT_W'(rd_data_reg) : '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (op_valid) begin
            rd_data_reg <= mem[op_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            p_valid_reg    <= 1'b0;
        end else begin
            if (sweep_reg) begin
                sweep_addr_reg <= sweep_addr_reg + IDX_BITS'(1);
                if (sweep_addr_reg == IDX_BITS'(NUM_BINS - 1)) begin
                    sweep_reg <= 1'b0;
                end
            end
            p_valid_reg <= op_valid;
        end
        if (op_valid) begin
            p_op_reg   <= op;
            p_addr_reg <= op_addr;
        end
    end

    assign busy      = sweep_reg;
    assign res_valid = p_valid_reg;

endmodule

`default_nettype wire

[rtl/equal_width_histogram.sv]
// Equal-width histogram over signed Q16.16 samples, counts in one synchronous memory.
// Flow: a read or clear goes from accept to the store; an add first runs the bin finder,
// whose range check clamps or whose restoring divide finds the bin, one quotient bit a cycle.
// Throughput: one item at a time; the next accept waits until the op is handed to the store,
// and later still if the result side stalls.
// Reset: synchronous, active low; then a zero sweep of every bin with s_tready low.
`default_nettype none

module equal_width_histogram #(
    parameter int NUM_BINS   = 128,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [ewh_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [ewh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // command stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [39:0]                     s_tdata,   // [31:0] sample, [38:32] bin_select
    input  wire logic [1:0]                      s_tuser,   // [1:0] cmd
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [39:0]                          m_tdata,   // [6:0] bin_index, [38:7] bin_count
    output logic                                 m_tuser    // [0] clamped
);
    import ewh_pkg::*;

    localparam int IDX_BITS = $clog2(NUM_BINS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BIN   = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;

    // configuration registers
    logic [SAMPLE_W-1:0]   low_edge_reg;
    logic [WIDTH_W-1:0]    bin_width_reg;
    logic [BINS_W-1:0]     bins_in_use_reg;

    logic [1:0]            state_reg;
    ewh_op_t               op_reg;
    logic [IDX_BITS-1:0]   addr_reg;

    logic                  in_beat;
    ewh_cmd_t              s_cmd;
    logic [SAMPLE_W-1:0]   s_sample;
    logic [SELECT_W-1:0]   s_bin_select;
    logic                  sel_in_range;

    logic                  bin_done;
    logic [IDX_BITS-1:0]   bin_found;
    logic                  bin_clamped;

    logic                  out_free;
    logic                  op_valid;
    logic                  store_busy;
    logic                  res_valid;
    ewh_result_t           res;

    logic                  m_tvalid_reg;
    logic [39:0]           m_tdata_reg;
    logic                  m_tuser_reg;

    assign s_cmd        = s_tuser;
    assign s_sample     = s_tdata[31:0];
    assign s_bin_select = s_tdata[38:32];
    assign sel_in_range = (32'(s_bin_select) < NUM_BINS);

    // Take a beat only with the sequencer idle and the zero sweep finished.
    assign s_tready = (state_reg == ST_IDLE) && !store_busy;
    assign in_beat  = s_tvalid && s_tready;

    // The output register is empty next cycle if it is empty now or drains now,
    // so the store may start an operation whose result reaches it in the following cycle.
    assign out_free = !m_tvalid_reg || m_tready;
    assign op_valid = (state_reg == ST_ISSUE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_edge_reg    <= '0;
            bin_width_reg   <= WIDTH_W'(65536);
            bins_in_use_reg <= BINS_W'(100);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LOW_EDGE:    low_edge_reg    <= cfg_wdata;
                REG_BIN_WIDTH:   bin_width_reg   <= cfg_wdata[WIDTH_W-1:0];
                REG_BINS_IN_USE: bins_in_use_reg <= cfg_wdata[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: accept, find the bin for an add, then hand one op to the store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        state_reg <= (s_cmd == CMD_ADD) ? ST_BIN : ST_ISSUE;
                    end
                end
                ST_BIN: begin
                    if (bin_done) begin
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Operation payload: capture select-driven fields on accept, bin fields on done.
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            op_reg.bin_index <= s_bin_select;
            op_reg.clamped   <= 1'b0;
            addr_reg         <= IDX_BITS'(s_bin_select);
            unique case (s_cmd)
                CMD_ADD: begin
                    op_reg.cmd      <= CMD_ADD;
                    op_reg.in_range <= 1'b1;
                end
                CMD_CLEAR: begin
                    op_reg.cmd      <= CMD_CLEAR;
                    op_reg.in_range <= sel_in_range;
                end
                default: begin
                    // the reserved code reads like a read
                    op_reg.cmd      <= CMD_READ;
                    op_reg.in_range <= sel_in_range;
                end
            endcase
        end else if (bin_done) begin
            op_reg.bin_index <= INDEX_W'(bin_found);
            op_reg.clamped   <= bin_clamped;
            addr_reg         <= bin_found;
        end
    end

    ewh_binner #(
        .NUM_BINS (NUM_BINS)
    ) u_binner (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_beat && (s_cmd == CMD_ADD)),
        .sample      (s_sample),
        .low_edge    (low_edge_reg),
        .bin_width   (bin_width_reg),
        .bins_in_use (bins_in_use_reg),
        .done        (bin_done),
        .bin         (bin_found),
        .clamped     (bin_clamped)
    );

    ewh_bin_store #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (op_valid),
        .op        (op_reg),
        .op_addr   (addr_reg),
        .busy      (store_busy),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: load a result, hold it until the far side takes the beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_valid) begin
            m_tdata_reg <= {1'b0, res.bin_count, res.bin_index};
            m_tuser_reg <= res.clamped;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A result never lands on an untaken beat.
    a_res_into_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !m_tvalid_reg)
        else $error("result overwrote a pending output beat");

    // The bin finder only reports while the sequencer waits on it.
    a_bin_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        bin_done |-> (state_reg == ST_BIN))
        else $error("bin result arrived outside the bin wait");

    // No store operation during the reset sweep.
    a_no_op_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        op_valid |-> !store_busy)
        else $error("store operation issued during zero sweep");

    // One item at a time: an accept drops ready for the next cycle.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_tready)
        else $error("second beat accepted while one is in flight");

endmodule

`default_nettype wire

[sim/tb_equal_width_histogram.sv]
// Self-checking testbench for equal_width_histogram: directed edge cases, then random traffic.
// Predicts every result from its own copy of the bin counts and registers and checks it.
// Depends on rtl/ewh_pkg.sv and rtl/equal_width_histogram.sv.
`default_nettype none

module tb_equal_width_histogram;

    import ewh_pkg::*;

    localparam int NUM_BINS      = 128;
    localparam int COUNT_BITS    = 32;
    localparam int WATCHDOG_MAX  = 5000;  // cycles without any beat before giving up
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_ITEMS = 136;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;  // [31:0] sample, [38:32] bin_select
    logic [1:0]  s_tuser   = '0;  // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;         // [6:0] bin_index, [38:7] bin_count
    logic        m_tuser;         // [0] clamped

    equal_width_histogram #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Shadow of the configuration registers, updated when a write is seen on the port.
    logic [31:0] low_edge_q    = 32'd0;
    logic [30:0] bin_width_q   = 31'd65536;
    logic [7:0]  bins_in_use_q = 8'd100;

    // Predicted bin counts; cleared at reset like the store.
    logic [COUNT_BITS-1:0] bin_tally [NUM_BINS];

    ewh_result_t pending_results [$];

    // Idle and stall odds, percent per cycle; changed between phases.
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_stall_pct = 0;

    int unsigned mismatches     = 0;
    int unsigned results_seen   = 0;
    int unsigned adds_seen      = 0;
    int unsigned clamped_seen   = 0;
    int unsigned reads_seen     = 0;
    int unsigned clears_seen    = 0;
    int unsigned quiet_cycles   = 0;

    initial begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
    end

    // Effective bin count and width, with the zero and oversize cases folded in.
    function automatic longint unsigned bins_effective();
        if (bins_in_use_q == 8'd0) return 1;
        if (bins_in_use_q > NUM_BINS) return NUM_BINS;
        return longint'(bins_in_use_q);
    endfunction

    function automatic longint unsigned width_effective();
        return (bin_width_q == '0) ? 1 : longint'(bin_width_q);
    endfunction

    // Apply one command to the predicted counts and return the result it must produce.
    function automatic ewh_result_t tally_command(ewh_cmd_t cmd, logic [31:0] sample,
                                                  logic [6:0] sel);
        ewh_result_t       r;
        longint            diff;
        longint unsigned   quot;
        longint unsigned   n;
        int unsigned       bin;
        r = '0;
        n = bins_effective();
        case (cmd)
            CMD_ADD: begin
                diff = longint'($signed(sample)) - longint'($signed(low_edge_q));
                if (diff < 0) begin
                    bin = 0;
                    r.clamped = 1'b1;
                end else begin
                    quot = longint'(diff) / width_effective();
                    if (quot >= n) begin
                        bin = int'(n) - 1;
                        r.clamped = 1'b1;
                    end else begin
                        bin = int'(quot);
                    end
                end
                // saturate instead of wrapping
                if (bin_tally[bin] != '1) bin_tally[bin] = bin_tally[bin] + 1'b1;
                r.bin_index = bin[6:0];
                r.bin_count = bin_tally[bin];
            end
            CMD_CLEAR: begin
                bin_tally[sel] = '0;
                r.bin_index = sel;
            end
            default: begin
                // read, and the unused code acting as a read
                r.bin_index = sel;
                r.bin_count = bin_tally[sel];
            end
        endcase
        return r;
    endfunction

    // Receiver: drop m_tready at random according to the current stall odds.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Observe both channels and the register port at each edge: values read here are
    // the ones that were stable before the edge, so the order of processes does not matter.
    always @(posedge aclk) begin : monitor
        ewh_result_t want;
        logic        beat;
        if (aresetn) begin
            beat = 1'b0;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_LOW_EDGE:    low_edge_q    = cfg_wdata;
                    REG_BIN_WIDTH:   bin_width_q   = cfg_wdata[30:0];
                    REG_BINS_IN_USE: bins_in_use_q = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                beat = 1'b1;
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: index %0d count %0d clamped %0d",
                                 m_tdata[6:0], m_tdata[38:7], m_tuser);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[6:0] !== want.bin_index || m_tdata[38:7] !== want.bin_count ||
                        m_tuser !== want.clamped) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected index %0d count %0d clamped %0d",
                                     want.bin_index, want.bin_count, want.clamped);
                            $display("          got      index %0d count %0d clamped %0d",
                                     m_tdata[6:0], m_tdata[38:7], m_tuser);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                beat = 1'b1;
                want = tally_command(s_tuser, s_tdata[31:0], s_tdata[38:32]);
                pending_results = {pending_results, want};
                case (s_tuser)
                    CMD_ADD:   adds_seen++;
                    CMD_CLEAR: clears_seen++;
                    default:   reads_seen++;
                endcase
                if (s_tuser == CMD_ADD && want.clamped) clamped_seen++;
            end
            // watchdog: any beat restarts the count
            quiet_cycles = beat ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results.size());
                $display("tb_equal_width_histogram NOT OK");
                $finish;
            end
        end
    end

    // Offer one command; hold it until the block takes it. s_tvalid stays high after the
    // beat so that a following item can go out back to back.
    task automatic send_item(input ewh_cmd_t cmd, input logic [31:0] sample,
                             input logic [6:0] sel);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 40'({$urandom, $urandom});
            s_tuser  <= 2'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, sel, sample};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Write all three registers on consecutive edges; call only while the block is idle.
    task automatic write_config(input logic [31:0] low, input logic [31:0] width_word,
                                input logic [31:0] bins_word);
        logic [31:0] words [3];
        logic [1:0]  addrs [3];
        words = '{low, width_word, bins_word};
        addrs = '{REG_LOW_EDGE, REG_BIN_WIDTH, REG_BINS_IN_USE};
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_wdata <= words[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Reset values: bin edges at every whole number from 0, 100 bins.
    task automatic test_reset_defaults();
        send_item(CMD_ADD, 32'h0000_0000, 7'd0);     // lower edge of bin 0
        send_item(CMD_ADD, 32'h0000_FFFF, 7'd0);     // just under the next edge
        send_item(CMD_ADD, 32'h0001_0000, 7'd0);     // exactly on the next edge
        send_item(CMD_ADD, 32'h0063_FFFF, 7'd0);     // top of the last bin in use
        send_item(CMD_ADD, 32'h0064_0000, 7'd0);     // end of last bin: saturate high
        send_item(CMD_ADD, 32'h7FFF_FFFF, 7'd0);     // largest sample
        send_item(CMD_ADD, 32'hFFFF_FFFF, 7'd0);     // just below the first bin
        send_item(CMD_ADD, 32'h8000_0000, 7'd0);     // most negative sample
        send_item(CMD_READ, 32'hFFFF_FFFF, 7'd0);
        send_item(CMD_READ, 32'h0, 7'd99);
        send_item(CMD_READ, 32'h0, 7'd127);          // outside the bins in use
        send_item(CMD_CLEAR, 32'hA5A5_5A5A, 7'd99);
        send_item(CMD_READ, 32'h0, 7'd99);
        send_item(CMD_RSVD, 32'h1234_5678, 7'd0);    // unused code reads
        send_item(CMD_CLEAR, 32'h0, 7'd127);         // clear outside the bins in use
        wait_for_results();
    endtask

    // Register extremes: zero width, zero and oversize bin counts, full-scale edges.
    task automatic test_register_extremes();
        // width word has only bit 31 set, so the width field is zero; bins field is zero
        write_config(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FF00);
        send_item(CMD_ADD, 32'h8000_0000, 7'd0);     // exactly at the lower edge
        send_item(CMD_ADD, 32'h8000_0001, 7'd0);     // past the single bin
        send_item(CMD_ADD, 32'h7FFF_FFFF, 7'd0);
        wait_for_results();
        write_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd200);
        send_item(CMD_ADD, 32'h8000_0000, 7'd0);     // far below the lower edge
        send_item(CMD_ADD, 32'h7FFF_FFFF, 7'd0);
        wait_for_results();
        write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd255);
        send_item(CMD_ADD, 32'h7FFF_FFFF, 7'd0);     // widest span: third bin
        send_item(CMD_ADD, 32'hFFFF_FFFF, 7'd0);
        send_item(CMD_READ, 32'h0, 7'd2);
        send_item(CMD_READ, 32'h0, 7'd127);
        wait_for_results();
    endtask

    // Pick a sample that mostly lands in or just around the bins in use.
    function automatic logic [31:0] pick_sample();
        longint unsigned n;
        longint unsigned w;
        longint          target;
        longint          k;
        longint          offset;
        n = bins_effective();
        w = width_effective();
        case ($urandom_range(99) / 5)
            0, 1, 2: return $urandom;
            3, 4: begin
                case ($urandom_range(5))
                    0: target = -64'sd2147483648;
                    1: target = 64'sd2147483647;
                    2: target = longint'($signed(low_edge_q));
                    3: target = longint'($signed(low_edge_q)) - 1;
                    4: target = longint'($signed(low_edge_q)) + longint'(n * w);
                    default: target = longint'($signed(low_edge_q)) + longint'(n * w) - 1;
                endcase
            end
            default: begin
                k = longint'($urandom_range(int'(n) + 1)) - 1;
                case ($urandom_range(2))
                    0: offset = 0;
                    1: offset = longint'(w) - 1;
                    default: offset = longint'($urandom_range(32'(w - 1)));
                endcase
                target = longint'($signed(low_edge_q)) + k * longint'(w) + offset;
            end
        endcase
        if (target < -64'sd2147483648) target = -64'sd2147483648;
        if (target > 64'sd2147483647) target = 64'sd2147483647;
        return target[31:0];
    endfunction

    // Random traffic over several register settings and every idle/stall phase.
    task automatic test_random_traffic();
        logic [31:0]  low;
        logic [31:0]  width_word;
        logic [31:0]  bins_word;
        int unsigned  pause_at;
        int unsigned  pick;
        longint unsigned n;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_for_results();
            case (seg)
                0: begin low = 32'hFFF6_0000; width_word = 32'h0001_0000; bins_word = 32'd128; end
                1: begin low = 32'h8000_0000; width_word = 32'h7FFF_FFFF; bins_word = 32'd255; end
                2: begin low = 32'h7FFF_FFFF; width_word = 32'd1;         bins_word = 32'd0;   end
                3: begin low = $urandom;      width_word = 32'd0;         bins_word = 32'd1;   end
                4: begin
                    low        = 32'($urandom_range(32'h00FF_FFFF)) - 32'h0080_0000;
                    width_word = $urandom_range(32'h0010_0000, 1);
                    bins_word  = $urandom_range(128, 1);
                end
                5: begin low = 32'd0; width_word = 32'd3; bins_word = 32'd128; end
                6: begin low = $urandom; width_word = $urandom; bins_word = $urandom; end
                default: begin low = 32'd0; width_word = 32'd65536; bins_word = 32'd100; end
            endcase
            write_config(low, width_word, bins_word);
            // cycle through: no idling, sender idle, receiver stalling, both a little
            case (seg % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
                default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
            endcase
            // wait for the next edge so the register shadow is current before picking samples
            @(posedge aclk);
            n = bins_effective();
            pause_at = $urandom_range(SEGMENT_ITEMS - 1, 1);
            for (int i = 0; i < SEGMENT_ITEMS; i++) begin
                if (i == pause_at) wait_for_results();
                pick = $urandom_range(99);
                if (pick < 62)
                    send_item(CMD_ADD, pick_sample(), 7'($urandom));
                else if (pick < 82)
                    send_item(CMD_READ, $urandom,
                              ($urandom_range(4) != 0) ? 7'($urandom_range(32'(n - 1)))
                                                       : 7'($urandom));
                else if (pick < 94)
                    send_item(CMD_CLEAR, $urandom,
                              ($urandom_range(4) != 0) ? 7'($urandom_range(32'(n - 1)))
                                                       : 7'($urandom));
                else
                    send_item(CMD_RSVD, $urandom, 7'($urandom));
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    initial begin
        // hold reset, then release; the block sweeps its store before it takes a beat
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();

        wait_for_results();
        // let any stray result show up before judging
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0) mismatches++;

        $display("covered %0d adds (%0d saturated into an end bin), %0d reads, %0d clears",
                 adds_seen, clamped_seen, reads_seen, clears_seen);
        $display("over 12 register settings and 4 idle/stall phases; %0d results, %0d bad",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_equal_width_histogram OK");
        end else begin
            $display("tb_equal_width_histogram NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
